FILE: src/rsd_pkg.sv
// Shared types and constants for the RLE sprite row downscaler.
// No dependencies; imported by the core, the output queue and the top level.
package rsd_pkg;

	// Scale limit and register reset values
	localparam int MAX_SCALE_SHIFT_DEF = 3;
	localparam logic [1:0] SCALE_SHIFT_RST = 2'd1;
	localparam logic COUNTS_ONLY_RST = 1'b0;

	// Configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_ONLY = 1'b1;

	// Coding constants
	localparam logic [7:0] ROW_DELIM = 8'hFF;
	localparam logic [7:0] COUNT_SAT = 8'd254;

	// Parse phases
	localparam logic [1:0] PH_SKIP = 2'd0;
	localparam logic [1:0] PH_COUNT = 2'd1;
	localparam logic [1:0] PH_PRE = 2'd2;
	localparam logic [1:0] PH_POST = 2'd3;

	// Output queue geometry
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_LVL_W = $clog2(OQ_DEPTH + 1);

	// One result word
	typedef struct packed {
		logic [7:0] out_byte;
		logic row_end;
		logic last_of_run;
	} rsd_result_t;

	// Results produced by one processed input word
	typedef struct packed {
		logic [1:0] cnt;
		rsd_result_t res0;
		rsd_result_t res1;
	} rsd_push_t;

	// Output queue status seen by the core
	typedef struct packed {
		logic room2;
		logic [OQ_LVL_W-1:0] level;
	} rsd_oq_stat_t;

endpackage

FILE: src/rsd_in_if.sv
// Input channel: one coded row byte per word, valid/ready handshake.
// No dependencies.
interface rsd_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

FILE: src/rsd_out_if.sv
// Output channel: one downscaled row byte plus flags per word, valid/ready handshake.
// No dependencies.
interface rsd_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic row_end;
	logic last_of_run;

	modport source(output valid, output out_byte, output row_end, output last_of_run,
		input ready);
	modport sink(input valid, input out_byte, input row_end, input last_of_run,
		output ready);
endinterface

FILE: src/rsd_core.sv
// Row parser and scaler: input register, row state and per-byte result logic.
// Depends on rsd_pkg and rsd_in_if.
module rsd_core #(
	parameter int MAX_SCALE_SHIFT = rsd_pkg::MAX_SCALE_SHIFT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rsd_in_if.sink               in_ch,
	input  logic [1:0]           scale_shift,
	input  logic                 counts_only,
	input  rsd_pkg::rsd_oq_stat_t oq_stat,
	output rsd_pkg::rsd_push_t   push
);
	import rsd_pkg::*;

	// Shift never exceeds the 2-bit register range or the parameter
	localparam int SHIFT_LIM = (MAX_SCALE_SHIFT < 3) ? MAX_SCALE_SHIFT : 3;
	localparam int POS_W = (SHIFT_LIM > 0) ? SHIFT_LIM : 1;
	localparam int RST_SHIFT = (int'(SCALE_SHIFT_RST) > SHIFT_LIM) ? SHIFT_LIM
		: int'(SCALE_SHIFT_RST);
	localparam logic [POS_W-1:0] RST_MASK = POS_W'((1 << RST_SHIFT) - 1);

	// Input register
	logic [7:0] byte_s1;
	logic valid_s1;
	logic fire;

	// Row state
	logic [1:0] phase_q, phase_n;
	logic [15:0] skip_q, skip_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [7:0] left_q, left_n;
	logic kept_q, kept_n;

	// Datapath
	logic [1:0] shift;
	logic [POS_W-1:0] mask;
	logic [POS_W-1:0] pos_m;
	logic [POS_W-1:0] start;
	logic [16:0] sum17;
	logic [16:0] first17;
	logic [7:0] first_b;
	logic [8:0] t9;
	logic [8:0] second9;
	logic [7:0] second_b;
	logic keep;
	logic [16:0] skip_add;
	logic [15:0] skip_sat;
	logic [8:0] f9;
	logic [7:0] left_dec;
	logic emit;
	logic [1:0] res_cnt;
	rsd_result_t res0, res1;

	assign fire = valid_s1 & oq_stat.room2;
	assign in_ch.ready = ~valid_s1 | fire;

	// Input register: refilled whenever it empties or drains this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.in_byte;
		end
	end

	// Effective factor and shared arithmetic
	always_comb begin
		shift = (int'(scale_shift) > MAX_SCALE_SHIFT) ? 2'(SHIFT_LIM) : scale_shift;
		mask = POS_W'((4'd1 << shift) - 4'd1);
		pos_m = pos_q & mask;
		sum17 = 17'(pos_m) + 17'(skip_q);
		start = POS_W'(sum17) & mask;
		first17 = sum17 >> shift;
		first_b = (first17 > 17'(COUNT_SAT)) ? COUNT_SAT : first17[7:0];
		t9 = 9'(start) + 9'(byte_s1);
		second9 = t9 >> shift;
		keep = (second9 != 9'd0);
		second_b = (second9 > 9'(COUNT_SAT)) ? COUNT_SAT : second9[7:0];
		skip_add = 17'(skip_q) + 17'(byte_s1);
		skip_sat = skip_add[16] ? 16'hFFFF : skip_add[15:0];
		f9 = 9'(mask) + 9'd1;
		left_dec = (left_q != 8'd0) ? (left_q - 8'd1) : 8'd0;
	end

	// Next state and results for the byte in the input register
	always_comb begin
		phase_n = phase_q;
		skip_n = skip_q;
		pos_n = pos_q;
		left_n = left_q;
		kept_n = kept_q;
		emit = 1'b0;
		res_cnt = 2'd0;
		res0 = '0;
		res1 = '0;
		unique case (phase_q)
			PH_SKIP: begin
				if (byte_s1 == ROW_DELIM) begin
					res_cnt = 2'd1;
					res0 = '{out_byte: ROW_DELIM, row_end: 1'b1, last_of_run: 1'b1};
					phase_n = PH_SKIP;
					skip_n = 16'd0;
					pos_n = mask;
					left_n = 8'd0;
					kept_n = 1'b0;
				end else begin
					skip_n = skip_sat;
					phase_n = PH_COUNT;
				end
			end
			PH_COUNT: begin
				if (keep) begin
					res_cnt = 2'd2;
					res0 = '{out_byte: first_b, row_end: 1'b0, last_of_run: 1'b0};
					res1 = '{out_byte: second_b, row_end: 1'b0, last_of_run: 1'b1};
					skip_n = 16'd0;
					if (counts_only) begin
						pos_n = POS_W'(t9) & mask;
						phase_n = PH_SKIP;
					end else begin
						pos_n = start;
						left_n = byte_s1;
						kept_n = 1'b1;
						phase_n = PH_PRE;
					end
				end else begin
					skip_n = skip_sat;
					if (!counts_only && byte_s1 != 8'd0) begin
						left_n = byte_s1;
						kept_n = 1'b0;
						phase_n = PH_PRE;
					end else begin
						phase_n = PH_SKIP;
					end
				end
			end
			PH_PRE, PH_POST: begin
				// pixel bytes: sample at factor boundaries of kept runs
				if (kept_q) begin
					if (phase_q == PH_PRE) begin
						if (pos_m == mask) begin
							emit = 1'b1;
							phase_n = PH_POST;
						end
					end else if (pos_m == '0 && 9'(left_q) >= f9) begin
						emit = 1'b1;
					end
					pos_n = (pos_m + POS_W'(1)) & mask;
				end
				if (emit) begin
					res_cnt = 2'd1;
					res0 = '{out_byte: byte_s1, row_end: 1'b0, last_of_run: 1'b1};
				end
				left_n = left_dec;
				if (left_dec == 8'd0) begin
					phase_n = PH_SKIP;
					kept_n = 1'b0;
				end
			end
			default: begin
				phase_n = PH_SKIP;
			end
		endcase
	end

	// Row state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			skip_q <= 16'd0;
			pos_q <= RST_MASK;
			left_q <= 8'd0;
			kept_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			skip_q <= skip_n;
			pos_q <= pos_n;
			left_q <= left_n;
			kept_q <= kept_n;
		end
	end

	assign push.cnt = fire ? res_cnt : 2'd0;
	assign push.res0 = res0;
	assign push.res1 = res1;

endmodule

FILE: src/rsd_oq.sv
// Output queue: takes up to two result words per cycle, gives one per cycle while out_ch is ready.
// Depends on rsd_pkg and rsd_out_if.
module rsd_oq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rsd_pkg::rsd_push_t    push,
	output rsd_pkg::rsd_oq_stat_t stat,
	rsd_out_if.source             out_ch
);
	import rsd_pkg::*;

	rsd_result_t mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] rd_q, wr_q;
	logic [OQ_LVL_W-1:0] lvl_q;
	logic pop;
	rsd_result_t head;

	assign pop = out_ch.valid & out_ch.ready;
	assign head = mem_q[rd_q];

	assign out_ch.valid = (lvl_q != '0);
	assign out_ch.out_byte = head.out_byte;
	assign out_ch.row_end = head.row_end;
	assign out_ch.last_of_run = head.last_of_run;

	assign stat.room2 = (lvl_q <= OQ_LVL_W'(OQ_DEPTH - 2));
	assign stat.level = lvl_q;

	// Storage writes
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.res0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_q + OQ_PTR_W'(1)] <= push.res1;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			lvl_q <= '0;
		end else begin
			wr_q <= wr_q + OQ_PTR_W'(push.cnt);
			if (pop) begin
				rd_q <= rd_q + OQ_PTR_W'(1);
			end
			lvl_q <= lvl_q + OQ_LVL_W'(push.cnt) - OQ_LVL_W'(pop);
		end
	end

endmodule

FILE: src/rle_sprite_row_downscaler.sv
// Top level of the RLE sprite row downscaler: configuration registers, core, output queue.
// Depends on rsd_pkg, rsd_in_if, rsd_out_if, rsd_core and rsd_oq.
//
// Usage:
// in_ch carries one byte of a run-length coded sprite row per word: skip count,
// pixel count, pixel bytes (none in counts-only mode), the row ended by 0xFF.
// out_ch carries the downscaled row, one byte per word, with row_end on the
// delimiter and last_of_run on the last word caused by each input byte.
// Registers are written through cfg_we/cfg_index/cfg_wdata (0: scale_shift,
// 1: counts_only) while the block is idle; they act on the next byte.
// An accepted byte passes through the input register and then the output queue
// before its first word is shown on out_ch.
// Throughput: one input byte per cycle while the queue has room; the output runs at one
// word per cycle while out_ch is ready, and a kept pixel count byte gives two words.
// The rate is set by the four-word output queue, which must have room for two
// words before the input register hands a byte to the row logic.
// Reset empties the input register and the queue and returns the row state and
// registers to their reset values. When out_ch stalls the queue fills, then
// in_ch.ready drops once the input register holds a byte; nothing is lost.
module rle_sprite_row_downscaler #(
	parameter int MAX_SCALE_SHIFT = rsd_pkg::MAX_SCALE_SHIFT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rsd_in_if.sink                         in_ch,
	rsd_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [rsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import rsd_pkg::*;

	logic [1:0] scale_shift_q;
	logic counts_only_q;
	rsd_push_t push;
	rsd_oq_stat_t oq_stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_shift_q <= SCALE_SHIFT_RST;
			counts_only_q <= COUNTS_ONLY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCALE_SHIFT: scale_shift_q <= cfg_wdata[1:0];
				CFG_COUNTS_ONLY: counts_only_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	rsd_core #(
		.MAX_SCALE_SHIFT(MAX_SCALE_SHIFT)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.scale_shift(scale_shift_q),
		.counts_only(counts_only_q),
		.oq_stat(oq_stat),
		.push(push)
	);

	rsd_oq u_oq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.stat(oq_stat),
		.out_ch(out_ch)
	);

	// Delimiter words are always 0xFF and close their input byte
	a_row_end_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.row_end |-> out_ch.out_byte == ROW_DELIM && out_ch.last_of_run)
		else $error("row_end word is not a closing 0xFF");

	// A two-word push is a count pair: only the second closes the byte
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |-> push.res1.last_of_run && !push.res0.last_of_run
			&& !push.res0.row_end && !push.res1.row_end)
		else $error("bad count pair flags");

	// Queue never overfills
	a_oq_level: assert property (@(posedge clk) disable iff (!arst_n)
		oq_stat.level <= OQ_LVL_W'(OQ_DEPTH))
		else $error("output queue overflow");

endmodule
